// ===== src/bubc_pkg.sv =====
// shared constants, types and helpers for the block usage bitmap checker
// no dependencies; imported by every other file of the block
package bubc_pkg;

  localparam int MAP_BLOCKS    = 65536;
  localparam int MISSING_LIMIT = 11;

  // map is stored as rows of WORD_W bits
  localparam int WORD_W = (MAP_BLOCKS >= 64) ? 32 : MAP_BLOCKS / 2;
  localparam int ROWS   = MAP_BLOCKS / WORD_W;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int IDX_W  = ROW_W + BIT_W;
  localparam int TOP_W  = ((IDX_W > 16) ? IDX_W : 16) + 2;
  localparam int CNT_W  = $clog2(MISSING_LIMIT + 1);

  localparam int FIRST_W    = 16;
  localparam int SIZE_W     = 17;
  localparam int ADDR_W     = 32;
  localparam int BLOCK_W    = 17;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FS_SIZE     = 1'd1;

  typedef enum logic [1:0] {
    KIND_USE   = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLAIM = 2'd2,
    KIND_SCAN  = 2'd3
  } kind_t;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    word_t            wr_data;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
  } map_req_t;

  typedef struct packed {
    logic used;
    logic dup;
    logic free;
    logic free_dup;
    logic bad;
  } stat_ev_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] used;
    logic [TOTAL_W-1:0] dup;
    logic [TOTAL_W-1:0] free;
    logic [TOTAL_W-1:0] free_dup;
    logic [TOTAL_W-1:0] bad;
  } totals_t;

  // position of the highest set bit, zero for an empty word
  function automatic logic [BIT_W-1:0] top_set_bit(word_t w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== src/bubc_if.sv =====
// request and result channel interfaces of the bitmap checker
// depends on bubc_pkg for field widths
interface bubc_req_if
  import bubc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] block_addr;

  modport source (output valid, kind, block_addr, input ready);
  modport sink (input valid, kind, block_addr, output ready);
endinterface

interface bubc_rsp_if
  import bubc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               rejected;
  logic               missing_valid;
  logic [BLOCK_W-1:0] missing_block;
  logic               truncated;
  logic               last;
  logic [TOTAL_W-1:0] used_total;
  logic [TOTAL_W-1:0] dup_total;
  logic [TOTAL_W-1:0] free_total;
  logic [TOTAL_W-1:0] free_dup_total;
  logic [TOTAL_W-1:0] bad_total;

  modport source (
    output valid, rejected, missing_valid, missing_block, truncated, last,
           used_total, dup_total, free_total, free_dup_total, bad_total,
    input  ready
  );
  modport sink (
    input  valid, rejected, missing_valid, missing_block, truncated, last,
           used_total, dup_total, free_total, free_dup_total, bad_total,
    output ready
  );
endinterface

// ===== src/bubc_map.sv =====
// usage bitmap storage: one write port, one read port with registered data
// depends on bubc_pkg
module bubc_map
  import bubc_pkg::*;
(
  input  logic     clk,
  input  map_req_t map_req,
  output word_t    rdata
);

  word_t mem [ROWS];

  always_ff @(posedge clk) begin
    if (map_req.wr_en) begin
      mem[map_req.wr_row] <= map_req.wr_data;
    end
    if (map_req.rd_en) begin
      rdata <= mem[map_req.rd_row];
    end
  end

endmodule

// ===== src/bubc_stats.sv =====
// saturating event counters of the bitmap checker
// depends on bubc_pkg; totals_next shows the values after this cycle's events
module bubc_stats
  import bubc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  stat_ev_t ev,
  output totals_t  totals_next
);

  totals_t totals;

  function automatic logic [TOTAL_W-1:0] sat_inc(logic [TOTAL_W-1:0] c, logic en);
    logic [TOTAL_W-1:0] r;
    r = c;
    if (en && (c != '1)) begin
      r = c + TOTAL_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    totals_next.used     = sat_inc(totals.used, ev.used);
    totals_next.dup      = sat_inc(totals.dup, ev.dup);
    totals_next.free     = sat_inc(totals.free, ev.free);
    totals_next.free_dup = sat_inc(totals.free_dup, ev.free_dup);
    totals_next.bad      = sat_inc(totals.bad, ev.bad);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      totals <= '0;
    end else begin
      totals <= totals_next;
    end
  end

endmodule

// ===== src/bubc_ctrl.sv =====
// sequencer: map clearing, mark read-modify-write, scan walk, result register
// depends on bubc_pkg and the channel interfaces
module bubc_ctrl
  import bubc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bubc_req_if.sink              req,
  bubc_rsp_if.source            rsp,
  output map_req_t              map_req,
  input  word_t                 rdata,
  output stat_ev_t              ev,
  input  totals_t               totals_next
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_LOAD,
    ST_SEARCH,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic               rejected;
    logic               missing_valid;
    logic [BLOCK_W-1:0] missing_block;
    logic               truncated;
    logic               last;
    totals_t            totals;
  } res_t;

  state_t             state, state_next;
  logic [FIRST_W-1:0] first_block, first_block_next;
  logic [SIZE_W-1:0]  fs_size, fs_size_next;
  kind_t              item_kind, item_kind_next;
  logic               item_in_range, item_in_range_next;
  logic               item_zero, item_zero_next;
  logic [IDX_W-1:0]   item_idx, item_idx_next;
  logic [ROW_W-1:0]   row, row_next;
  logic               first_row, first_row_next;
  logic [BIT_W-1:0]   top_bit, top_bit_next;
  word_t              zmask, zmask_next;
  logic               pend_valid, pend_valid_next;
  logic [BLOCK_W-1:0] pend_block, pend_block_next;
  logic [CNT_W-1:0]   n_found, n_found_next;
  logic               res_valid, res_valid_next;
  res_t               res, res_next;

  logic [TOP_W-1:0]  lo_ext, cap, size_ext, top, blk_sum;
  logic [ADDR_W-1:0] addr_pos;
  logic              in_range, scan_nonempty, can_emit, hit;
  logic [IDX_W-1:0]  req_idx, hi_idx, new_idx;
  logic [BIT_W-1:0]  found_bit;
  logic [CNT_W-1:0]  n_inc;
  word_t             top_mask;

  assign req.ready = (state == ST_IDLE);
  assign can_emit  = !res_valid || rsp.ready;

  assign rsp.valid          = res_valid;
  assign rsp.rejected       = res.rejected;
  assign rsp.missing_valid  = res.missing_valid;
  assign rsp.missing_block  = res.missing_block;
  assign rsp.truncated      = res.truncated;
  assign rsp.last           = res.last;
  assign rsp.used_total     = res.totals.used;
  assign rsp.dup_total      = res.totals.dup;
  assign rsp.free_total     = res.totals.free;
  assign rsp.free_dup_total = res.totals.free_dup;
  assign rsp.bad_total      = res.totals.bad;

  // valid range is first_block up to min(fs_size, first_block + map size)
  always_comb begin
    lo_ext        = TOP_W'(first_block);
    cap           = lo_ext + TOP_W'(MAP_BLOCKS);
    size_ext      = TOP_W'(fs_size);
    top           = (size_ext < cap) ? size_ext : cap;
    addr_pos      = {1'b0, req.block_addr[ADDR_W-2:0]};
    in_range      = !req.block_addr[ADDR_W-1] && (addr_pos >= ADDR_W'(lo_ext)) &&
                    (addr_pos < ADDR_W'(top));
    req_idx       = IDX_W'(addr_pos - ADDR_W'(lo_ext));
    scan_nonempty = top > lo_ext;
    hi_idx        = IDX_W'(top - lo_ext - TOP_W'(1));
    found_bit     = top_set_bit(zmask);
    new_idx       = {row, found_bit};
    blk_sum       = lo_ext + TOP_W'(new_idx);
    n_inc         = n_found + CNT_W'(1);
    top_mask      = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - top_bit);
    hit           = rdata[item_idx[BIT_W-1:0]];
  end

  always_comb begin
    state_next         = state;
    first_block_next   = first_block;
    fs_size_next       = fs_size;
    item_kind_next     = item_kind;
    item_in_range_next = item_in_range;
    item_zero_next     = item_zero;
    item_idx_next      = item_idx;
    row_next           = row;
    first_row_next     = first_row;
    top_bit_next       = top_bit;
    zmask_next         = zmask;
    pend_valid_next    = pend_valid;
    pend_block_next    = pend_block;
    n_found_next       = n_found;
    res_valid_next     = res_valid && !rsp.ready;
    res_next           = res;
    res_next.totals    = totals_next;
    map_req            = '0;
    ev                 = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_BLOCK: first_block_next = cfg_data[FIRST_W-1:0];
        REG_FS_SIZE:     fs_size_next = cfg_data[SIZE_W-1:0];
      endcase
    end

    unique case (state)
      ST_CLEAR: begin
        map_req.wr_en  = 1'b1;
        map_req.wr_row = row;
        map_req.wr_data = '0;
        row_next       = row + ROW_W'(1);
        if (row == ROW_W'(ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req.valid) begin
          item_kind_next     = kind_t'(req.kind);
          item_in_range_next = in_range;
          item_zero_next     = (req.block_addr == '0);
          item_idx_next      = req_idx;
          pend_valid_next    = 1'b0;
          n_found_next       = '0;
          if (kind_t'(req.kind) == KIND_SCAN) begin
            row_next       = hi_idx[IDX_W-1:BIT_W];
            first_row_next = 1'b1;
            top_bit_next   = hi_idx[BIT_W-1:0];
            map_req.rd_en  = scan_nonempty;
            map_req.rd_row = hi_idx[IDX_W-1:BIT_W];
            state_next     = scan_nonempty ? ST_LOAD : ST_FLUSH;
          end else begin
            map_req.rd_en  = in_range;
            map_req.rd_row = req_idx[IDX_W-1:BIT_W];
            state_next     = ST_MARK;
          end
        end
      end

      ST_MARK: begin
        if (can_emit) begin
          res_next.missing_valid = 1'b0;
          res_next.missing_block = '0;
          res_next.truncated     = 1'b0;
          res_next.last          = 1'b1;
          res_next.rejected      = 1'b1;
          if (!item_in_range) begin
            // block 0 given to mark-in-use is dropped silently
            if (item_kind == KIND_USE && item_zero) begin
              res_next.rejected = 1'b0;
            end else begin
              ev.bad = (item_kind == KIND_USE) || (item_kind == KIND_FREE);
            end
          end else if (hit) begin
            ev.dup      = (item_kind == KIND_USE);
            ev.free_dup = (item_kind == KIND_FREE);
          end else begin
            map_req.wr_en   = 1'b1;
            map_req.wr_row  = item_idx[IDX_W-1:BIT_W];
            map_req.wr_data = rdata | (word_t'(1) << item_idx[BIT_W-1:0]);
            ev.used         = (item_kind == KIND_USE);
            ev.free         = (item_kind == KIND_FREE);
            res_next.rejected = 1'b0;
          end
          res_next.totals = totals_next;
          res_valid_next  = 1'b1;
          state_next      = ST_IDLE;
        end
      end

      ST_LOAD: begin
        zmask_next = ~rdata & (first_row ? top_mask : {WORD_W{1'b1}});
        state_next = ST_SEARCH;
      end

      ST_SEARCH: begin
        if (zmask != '0) begin
          // a report is held back until the next one shows it is not the final one
          if (!pend_valid || can_emit) begin
            if (pend_valid) begin
              res_next.rejected      = 1'b0;
              res_next.missing_valid = 1'b1;
              res_next.missing_block = pend_block;
              res_next.truncated     = 1'b0;
              res_next.last          = 1'b0;
              res_valid_next         = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_block_next = blk_sum[BLOCK_W-1:0];
            zmask_next      = zmask & ~(word_t'(1) << found_bit);
            n_found_next    = n_inc;
            if (n_inc == CNT_W'(MISSING_LIMIT)) begin
              state_next = ST_FLUSH;
            end
          end
        end else if (row == '0) begin
          state_next = ST_FLUSH;
        end else begin
          map_req.rd_en  = 1'b1;
          map_req.rd_row = row - ROW_W'(1);
          row_next       = row - ROW_W'(1);
          first_row_next = 1'b0;
          state_next     = ST_LOAD;
        end
      end

      ST_FLUSH: begin
        if (can_emit) begin
          res_next.rejected      = 1'b0;
          res_next.missing_valid = pend_valid;
          res_next.missing_block = pend_valid ? pend_block : '0;
          res_next.truncated     = pend_valid && (n_found == CNT_W'(MISSING_LIMIT));
          res_next.last          = 1'b1;
          res_valid_next         = 1'b1;
          state_next             = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      row         <= '0;
      first_block <= FIRST_W'(2);
      fs_size     <= SIZE_W'(2);
      res_valid   <= 1'b0;
      pend_valid  <= 1'b0;
      n_found     <= '0;
    end else begin
      state       <= state_next;
      row         <= row_next;
      first_block <= first_block_next;
      fs_size     <= fs_size_next;
      res_valid   <= res_valid_next;
      pend_valid  <= pend_valid_next;
      n_found     <= n_found_next;
    end
    item_kind     <= item_kind_next;
    item_in_range <= item_in_range_next;
    item_zero     <= item_zero_next;
    item_idx      <= item_idx_next;
    first_row     <= first_row_next;
    top_bit       <= top_bit_next;
    zmask         <= zmask_next;
    pend_block    <= pend_block_next;
    res           <= res_next;
  end

endmodule

// ===== src/block_usage_bitmap_checker_top.sv =====
// block usage bitmap checker, top level
// mark and claim transactions, one at a time: read-modify-write of one row of the synchronous map
//   memory, read on acceptance and written back with the result in ST_MARK, held by rsp stalls
// scan transactions: each 32-block map row walked is loaded and searched, then a final report
// reset: the map memory is cleared one row a cycle (2048 rows, ROWS) with req.ready low
// depends on bubc_pkg, bubc_if, bubc_map, bubc_stats and bubc_ctrl
module block_usage_bitmap_checker_top
  import bubc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bubc_req_if.sink              req,
  bubc_rsp_if.source            rsp
);

  map_req_t map_req;
  word_t    rdata;
  stat_ev_t ev;
  totals_t  totals_next;

  bubc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req         (req),
    .rsp         (rsp),
    .map_req     (map_req),
    .rdata       (rdata),
    .ev          (ev),
    .totals_next (totals_next)
  );

  bubc_map u_map (
    .clk     (clk),
    .map_req (map_req),
    .rdata   (rdata)
  );

  bubc_stats u_stats (
    .clk         (clk),
    .rst         (rst),
    .ev          (ev),
    .totals_next (totals_next)
  );

endmodule

// ===== tb/tb_bitmap_result_checker.sv =====
`timescale 1ns / 100ps
// result checker for the block usage bitmap checker: shadow bitmap, counters and expected results
// depends on bubc_pkg and on the request and result interfaces in bubc_if
module tb_bitmap_result_checker
  import bubc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bubc_req_if                   req,
  bubc_rsp_if                   rsp,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  typedef struct {
    logic               rejected;
    logic               missing_valid;
    logic [BLOCK_W-1:0] missing_block;
    logic               truncated;
    logic               last;
    totals_t            totals;
  } block_result_t;

  bit                 map_shadow [MAP_BLOCKS];
  logic [FIRST_W-1:0] shadow_first;
  logic [SIZE_W-1:0]  shadow_size;
  totals_t            shadow_totals;
  block_result_t      expected_results [$];

  function automatic logic [TOTAL_W-1:0] sat_up(logic [TOTAL_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic void push_result(logic rej, logic mv, logic [BLOCK_W-1:0] mb, logic tr,
                                      logic lst);
    block_result_t r;
    r.rejected      = rej;
    r.missing_valid = mv;
    r.missing_block = mb;
    r.truncated     = tr;
    r.last          = lst;
    r.totals        = shadow_totals;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_block_results(kind_t kind, logic [ADDR_W-1:0] raw);
    longint addr;
    longint lo;
    longint top;
    longint a;
    int     found;
    int     idx;
    addr = longint'($signed(raw));
    lo   = longint'(shadow_first);
    top  = longint'(shadow_size);
    // size beyond the map is cut to the map
    if (top > lo + MAP_BLOCKS) top = lo + MAP_BLOCKS;
    if (kind == KIND_SCAN) begin
      found = 0;
      for (a = top - 1; a >= lo && found < MISSING_LIMIT; a--) begin
        if (!map_shadow[int'(a - lo)]) begin
          found++;
          push_result(1'b0, 1'b1, BLOCK_W'(a), found == MISSING_LIMIT, found == MISSING_LIMIT);
        end
      end
      if (found == 0) begin
        push_result(1'b0, 1'b0, '0, 1'b0, 1'b1);
      end else begin
        expected_results[expected_results.size() - 1].last = 1'b1;
      end
    end else if (addr < lo || addr >= top) begin
      // in-use mark of block zero outside the area is dropped silently
      if (kind == KIND_USE && addr == 0) begin
        push_result(1'b0, 1'b0, '0, 1'b0, 1'b1);
        return;
      end
      if (kind != KIND_CLAIM) shadow_totals.bad = sat_up(shadow_totals.bad);
      push_result(1'b1, 1'b0, '0, 1'b0, 1'b1);
    end else begin
      idx = int'(addr - lo);
      if (map_shadow[idx]) begin
        if (kind == KIND_USE) begin
          shadow_totals.dup = sat_up(shadow_totals.dup);
        end else if (kind == KIND_FREE) begin
          shadow_totals.free_dup = sat_up(shadow_totals.free_dup);
        end
        push_result(1'b1, 1'b0, '0, 1'b0, 1'b1);
      end else begin
        map_shadow[idx] = 1'b1;
        if (kind == KIND_USE) begin
          shadow_totals.used = sat_up(shadow_totals.used);
        end else if (kind == KIND_FREE) begin
          shadow_totals.free = sat_up(shadow_totals.free);
        end
        push_result(1'b0, 1'b0, '0, 1'b0, 1'b1);
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  task automatic check_result();
    block_result_t e;
    if (expected_results.size() == 0) begin
      report_mismatch("result transaction with none pending", rsp.last, 1'b0);
      return;
    end
    e = expected_results.pop_front();
    if (rsp.rejected !== e.rejected) report_mismatch("rejected", rsp.rejected, e.rejected);
    if (rsp.missing_valid !== e.missing_valid) begin
      report_mismatch("missing_valid", rsp.missing_valid, e.missing_valid);
    end
    if (rsp.missing_block !== e.missing_block) begin
      report_mismatch("missing_block", rsp.missing_block, e.missing_block);
    end
    if (rsp.truncated !== e.truncated) report_mismatch("truncated", rsp.truncated, e.truncated);
    if (rsp.last !== e.last) report_mismatch("last", rsp.last, e.last);
    if (rsp.used_total !== e.totals.used) begin
      report_mismatch("used_total", rsp.used_total, e.totals.used);
    end
    if (rsp.dup_total !== e.totals.dup) report_mismatch("dup_total", rsp.dup_total, e.totals.dup);
    if (rsp.free_total !== e.totals.free) begin
      report_mismatch("free_total", rsp.free_total, e.totals.free);
    end
    if (rsp.free_dup_total !== e.totals.free_dup) begin
      report_mismatch("free_dup_total", rsp.free_dup_total, e.totals.free_dup);
    end
    if (rsp.bad_total !== e.totals.bad) report_mismatch("bad_total", rsp.bad_total, e.totals.bad);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (map_shadow[i]) map_shadow[i] = 1'b0;
      shadow_first  = FIRST_W'(2);
      shadow_size   = SIZE_W'(2);
      shadow_totals = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FIRST_BLOCK: shadow_first = cfg_data[FIRST_W-1:0];
          REG_FS_SIZE:     shadow_size = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        check_result();
        checked++;
      end
      if (req.valid && req.ready) predict_block_results(kind_t'(req.kind), req.block_addr);
    end
    // registered so the stimulus side always sees the count of the previous edge
    pending <= expected_results.size();
  end

endmodule

// ===== tb/tb_block_usage_bitmap_checker_top.sv =====
`timescale 1ns / 100ps
// testbench top for the block usage bitmap checker: clock, reset, stimulus and verdict
// depends on bubc_pkg, bubc_if, the block top and tb_bitmap_result_checker
module tb_block_usage_bitmap_checker_top
  import bubc_pkg::*;
;

  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_LIMIT = 20000;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bubc_req_if req ();
  bubc_rsp_if rsp ();

  int          fail_count;
  int          pending;
  int          checked;
  rx_mode_t    rx_mode = RX_RANDOM;
  logic [15:0] rx_pattern = 16'hB5A7;
  logic [3:0]  rx_phase = '0;
  int          rx_hold = 0;
  bit          tx_gaps = 1'b1;
  int          burst_left = 0;
  int          items_sent = 0;
  int          scans_sent = 0;
  int          settings_used = 0;
  int          cur_first = 2;
  int          cur_size = 2;

  always #5 clk = ~clk;

  block_usage_bitmap_checker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  tb_bitmap_result_checker i_result_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // result side: long hold-off on request, otherwise the current stall mode
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rsp.ready <= 1'b0;
        rx_hold--;
      end else begin
        case (rx_mode)
          RX_ALWAYS: rsp.ready <= 1'b1;
          RX_RANDOM: rsp.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            rsp.ready <= rx_pattern[rx_phase];
            rx_phase++;
          end
        endcase
      end
    end
  end

  task automatic send_item(kind_t kind, logic [ADDR_W-1:0] addr);
    if (tx_gaps) begin
      if (burst_left == 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    req.valid      <= 1'b1;
    req.kind       <= kind;
    req.block_addr <= addr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
    if (kind == KIND_SCAN) scans_sent++;
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int first, int size);
    write_reg(REG_FIRST_BLOCK, CFG_DATA_W'(first));
    write_reg(REG_FS_SIZE, CFG_DATA_W'(size));
    cur_first = first & 32'hFFFF;
    cur_size  = size & 32'h1FFFF;
    settings_used++;
  endtask

  function automatic kind_t pick_kind();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return KIND_USE;
    if (sel < 60) return KIND_FREE;
    if (sel < 85) return KIND_CLAIM;
    return KIND_SCAN;
  endfunction

  // mostly inside the current area, plus zero, edges and anything at all
  function automatic logic [ADDR_W-1:0] pick_addr();
    longint lo;
    longint top;
    longint base;
    int     sel;
    lo  = cur_first;
    top = cur_size;
    if (top > lo + MAP_BLOCKS) top = lo + MAP_BLOCKS;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      base = 0;
    end else if (sel < 25) begin
      return $urandom();
    end else if (sel < 40) begin
      case ($urandom_range(0, 3))
        0:       base = lo - 1;
        1:       base = lo;
        2:       base = top - 1;
        default: base = top;
      endcase
    end else if (top > lo) begin
      base = lo + $urandom_range(0, int'(top - lo - 1));
    end else begin
      return $urandom();
    end
    return ADDR_W'(base);
  endfunction

  task automatic run_phase(int first, int size, int count, rx_mode_t mode, bit gaps,
                           bit long_hold);
    wait_idle();
    configure(first, size);
    rx_mode    = mode;
    rx_pattern = 16'($urandom()) | 16'h1001;
    tx_gaps    = gaps;
    burst_left = 0;
    if (long_hold) rx_hold = LONG_HOLD;
    repeat (count) send_item(pick_kind(), pick_addr());
  endtask

  initial begin
    int drain;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_FIRST_BLOCK;
    cfg_data       <= '0;
    req.valid      <= 1'b0;
    req.kind       <= KIND_USE;
    req.block_addr <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset setting: empty area
    send_item(KIND_USE, '0);
    send_item(KIND_FREE, '0);
    send_item(KIND_CLAIM, 32'd2);
    send_item(KIND_SCAN, '0);

    // whole map with block zero inside, size beyond the map
    wait_idle();
    configure(0, 17'h1FFFF);
    send_item(KIND_USE, '0);
    send_item(KIND_USE, '0);
    send_item(KIND_FREE, '0);
    send_item(KIND_FREE, 32'd65535);
    send_item(KIND_USE, 32'd65536);
    send_item(KIND_USE, 32'hFFFF_FFFF);
    send_item(KIND_FREE, 32'h8000_0000);
    send_item(KIND_CLAIM, 32'h7FFF_FFFF);
    send_item(KIND_CLAIM, 32'd1);
    send_item(KIND_CLAIM, 32'd1);
    send_item(KIND_SCAN, 32'hFFFF_FFFF);

    // four-block area: scans with one and then two blocks marked, then marks on both sides
    wait_idle();
    configure(100, 104);
    send_item(KIND_USE, 32'd103);
    send_item(KIND_SCAN, '0);
    send_item(KIND_FREE, 32'd102);
    send_item(KIND_SCAN, '0);
    send_item(KIND_USE, 32'd99);
    send_item(KIND_USE, 32'd104);

    // fifteen clear blocks: the last report hits the limit
    wait_idle();
    configure(200, 215);
    send_item(KIND_SCAN, '0);

    // highest area, first_block written with its unused data bit set
    wait_idle();
    configure(17'h1FFFF, 17'h1FFFF);
    send_item(KIND_USE, 32'd131070);
    send_item(KIND_FREE, 32'd65535);
    send_item(KIND_CLAIM, 32'd65534);
    send_item(KIND_SCAN, '0);

    run_phase(0, 17'h1FFFF, 55, RX_RANDOM, 1'b1, 1'b0);
    run_phase(1000, 1064, 60, RX_PATTERN, 1'b1, 1'b0);
    run_phase(0, 24, 40, RX_ALWAYS, 1'b0, 1'b0);
    begin
      int first;
      first = $urandom_range(0, 65535);
      run_phase(first, first + $urandom_range(1, 400), 55, RX_RANDOM, 1'b1, 1'b0);
    end
    run_phase(60000, 100, 15, RX_PATTERN, 1'b1, 1'b0);
    run_phase(65535, 17'h1FFFF, 35, RX_RANDOM, 1'b1, 1'b0);
    // result side held off so the block backs up into the request side
    run_phase(2000, 2600, 35, RX_ALWAYS, 1'b0, 1'b1);
    run_phase(30000, 65538, 45, RX_PATTERN, 1'b1, 1'b0);

    req.valid <= 1'b0;
    drain = 0;
    @(posedge clk);
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);

    $display("run covered %0d request transactions (%0d scans) over %0d area settings,",
             items_sent, scans_sent, settings_used);
    $display("with %0d result transactions checked and %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("block_usage_bitmap_checker_top test passed");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("block_usage_bitmap_checker_top test failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d results still expected", pending);
    $display("block_usage_bitmap_checker_top test failed");
    $finish;
  end

endmodule
